// ----- src/uhv_pkg.sv -----
// uhv_pkg: shared types, header constants and the byte-wide CRC-32 step
// for the legacy boot-image header validator. No dependencies.
`default_nettype none
package uhv_pkg;

  localparam int HDR_BYTES      = 64;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ARCH_CODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CRC_ENABLE = 2'd1;

  localparam logic [31:0] HDR_MAGIC  = 32'h2705_1956;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [7:0]  OS_LINUX           = 8'd5;
  localparam logic [7:0]  TYPE_KERNEL        = 8'd2;
  localparam logic [7:0]  TYPE_RAMDISK       = 8'd3;
  localparam logic [7:0]  TYPE_KERNEL_NOLOAD = 8'd14;
  localparam logic [7:0]  COMP_NONE          = 8'd0;
  localparam logic [7:0]  COMP_GZIP          = 8'd1;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NOT_IMAGE = 4'd1;
  localparam logic [3:0] ST_SHORT     = 4'd2;
  localparam logic [3:0] ST_HDR_CRC   = 4'd3;
  localparam logic [3:0] ST_TYPE      = 4'd4;
  localparam logic [3:0] ST_OS        = 4'd5;
  localparam logic [3:0] ST_ARCH      = 4'd6;
  localparam logic [3:0] ST_COMP      = 4'd7;
  localparam logic [3:0] ST_SIZE      = 4'd8;
  localparam logic [3:0] ST_DATA_CRC  = 4'd9;

  // Stream state as seen after the current byte has been taken in
  typedef struct packed {
    logic        short_buf;
    logic        size_bad;
    logic [31:0] magic;
    logic [31:0] hdr_crc_stored;
    logic [31:0] hdr_crc_run;
    logic [31:0] load_word;
    logic [31:0] entry_word;
    logic [31:0] data_crc_stored;
    logic [31:0] data_crc_run;
    logic [31:0] os_arch_type_comp;
  } uhv_view_t;

  typedef struct packed {
    logic [31:0] entry_point;
    logic [31:0] load_address;
    logic        is_ramdisk;
    logic        is_kernel;
    logic [7:0]  image_type;
    logic [3:0]  status;
  } uhv_result_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/uimage_header_validator.sv -----
// Legacy boot-image header validator: top level with input and result registers.
// Depends on uhv_pkg, uhv_capture and uhv_verdict.
//
// Bytes of an image buffer arrive one per transfer on the in_ stream, offset 0
// first, with in_tlast on the final byte. One byte is taken per cycle unless a
// last byte is held in the input register. Each byte passes through the input
// register, where the byte-wide CRC-32 update and header capture happen, and the
// verdict for a last byte lands in the result register as that byte leaves the
// input register. Bytes that yield no result keep flowing while a result waits;
// a last byte waits in the input register only while the previous result is
// still untaken. Stream state clears after each last byte. Configuration writes
// are meant for idle periods between buffers.
`default_nettype none
module uimage_header_validator #(
  parameter int LENGTH_BITS = 33
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata,  // status[3:0], image_type[11:4], is_kernel[12],
                                  // is_ramdisk[13], load_address[45:14],
                                  // entry_point[77:46], zero pad[79:78]
  input  wire                               cfg_we,
  input  wire  [uhv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [uhv_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import uhv_pkg::*;

  logic [7:0] arch_code_r;
  logic       crc_en_r;

  logic       s1_valid_r, s1_last_r;
  logic [7:0] s1_byte_r;
  logic       s1_go;
  logic       out_valid_r;
  uhv_result_t out_res_r;

  uhv_view_t   view;
  uhv_result_t result;

  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_code_r <= 8'd0;
      crc_en_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARCH_CODE:  arch_code_r <= cfg_wdata[7:0];
        CFG_CRC_ENABLE: crc_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  uhv_capture #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_go),
    .byte_data  (s1_byte_r),
    .byte_last  (s1_last_r),
    .view       (view)
  );

  uhv_verdict u_verdict (
    .arch_code (arch_code_r),
    .crc_en    (crc_en_r),
    .view      (view),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule
`default_nettype wire

// ----- src/uhv_capture.sv -----
// uhv_capture: byte counter, header field capture and both running CRCs.
// Depends on uhv_pkg.
`default_nettype none
module uhv_capture #(
  parameter int LENGTH_BITS = 33
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 byte_valid,
  input  wire  [7:0]          byte_data,
  input  wire                 byte_last,
  output uhv_pkg::uhv_view_t  view
);
  import uhv_pkg::*;

  localparam int CW = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;

  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0] hcrc_r, hcrc_nxt, dcrc_r, dcrc_nxt;
  logic [31:0] magic_r, magic_nxt, hstored_r, hstored_nxt, psize_r, psize_nxt;
  logic [31:0] load_r, load_nxt, entry_r, entry_nxt, dstored_r, dstored_nxt;
  logic [31:0] oatc_r, oatc_nxt;
  logic        sat;
  logic [5:0]  off6;
  logic [CW-1:0] cnt_ext, pay_end, len_ext, len_end;

  assign sat     = (cnt_r == {LENGTH_BITS{1'b1}});
  assign off6    = cnt_r[5:0];
  assign cnt_ext = CW'(cnt_r);
  assign pay_end = CW'(HDR_BYTES) + CW'(psize_r);

  always_comb begin
    cnt_nxt     = cnt_r;
    hcrc_nxt    = hcrc_r;
    dcrc_nxt    = dcrc_r;
    magic_nxt   = magic_r;
    hstored_nxt = hstored_r;
    psize_nxt   = psize_r;
    load_nxt    = load_r;
    entry_nxt   = entry_r;
    dstored_nxt = dstored_r;
    oatc_nxt    = oatc_r;
    if (byte_valid && !sat) begin
      if (cnt_ext < CW'(HDR_BYTES)) begin
        // header CRC field itself is hashed as zeros
        hcrc_nxt = crc_byte(hcrc_r, (off6 inside {[6'd4:6'd7]}) ? 8'd0 : byte_data);
        case (off6) inside
          [6'd0:6'd3]:   magic_nxt   = {magic_r[23:0], byte_data};
          [6'd4:6'd7]:   hstored_nxt = {hstored_r[23:0], byte_data};
          [6'd12:6'd15]: psize_nxt   = {psize_r[23:0], byte_data};
          [6'd16:6'd19]: load_nxt    = {load_r[23:0], byte_data};
          [6'd20:6'd23]: entry_nxt   = {entry_r[23:0], byte_data};
          [6'd24:6'd27]: dstored_nxt = {dstored_r[23:0], byte_data};
          [6'd28:6'd31]: oatc_nxt    = {oatc_r[23:0], byte_data};
          default: ;
        endcase
      end else if (cnt_ext < pay_end) begin
        dcrc_nxt = crc_byte(dcrc_r, byte_data);
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // length checks on the count after this byte
  assign len_ext = CW'(cnt_nxt);
  assign len_end = CW'(HDR_BYTES) + CW'(psize_nxt);

  always_comb begin
    view.short_buf         = (len_ext < CW'(HDR_BYTES));
    view.size_bad          = (len_end > len_ext);
    view.magic             = magic_nxt;
    view.hdr_crc_stored    = hstored_nxt;
    view.hdr_crc_run       = hcrc_nxt;
    view.load_word         = load_nxt;
    view.entry_word        = entry_nxt;
    view.data_crc_stored   = dstored_nxt;
    view.data_crc_run      = dcrc_nxt;
    view.os_arch_type_comp = oatc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && byte_last)) begin
      cnt_r     <= '0;
      hcrc_r    <= '1;
      dcrc_r    <= '1;
      magic_r   <= '0;
      hstored_r <= '0;
      psize_r   <= '0;
      load_r    <= '0;
      entry_r   <= '0;
      dstored_r <= '0;
      oatc_r    <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      hcrc_r    <= hcrc_nxt;
      dcrc_r    <= dcrc_nxt;
      magic_r   <= magic_nxt;
      hstored_r <= hstored_nxt;
      psize_r   <= psize_nxt;
      load_r    <= load_nxt;
      entry_r   <= entry_nxt;
      dstored_r <= dstored_nxt;
      oatc_r    <= oatc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/uhv_verdict.sv -----
// uhv_verdict: ordered header and CRC checks giving one result item.
// Depends on uhv_pkg.
`default_nettype none
module uhv_verdict (
  input  wire                   [7:0] arch_code,
  input  wire                         crc_en,
  input  wire uhv_pkg::uhv_view_t     view,
  output uhv_pkg::uhv_result_t        result
);
  import uhv_pkg::*;

  logic [7:0] os_b, arch_b, type_b, comp_b;
  logic       type_ok, comp_ok;
  logic [3:0] status;

  assign os_b   = view.os_arch_type_comp[31:24];
  assign arch_b = view.os_arch_type_comp[23:16];
  assign type_b = view.os_arch_type_comp[15:8];
  assign comp_b = view.os_arch_type_comp[7:0];

  assign type_ok = (type_b == TYPE_KERNEL) || (type_b == TYPE_KERNEL_NOLOAD) ||
                   (type_b == TYPE_RAMDISK);
  assign comp_ok = (comp_b == COMP_NONE) || (crc_en && (comp_b == COMP_GZIP));

  always_comb begin
    if (view.short_buf)                                          status = ST_SHORT;
    else if (view.magic != HDR_MAGIC)                            status = ST_NOT_IMAGE;
    else if (crc_en && (~view.hdr_crc_run != view.hdr_crc_stored)) status = ST_HDR_CRC;
    else if (!type_ok)                                           status = ST_TYPE;
    else if (os_b != OS_LINUX)                                   status = ST_OS;
    else if (arch_b != arch_code)                                status = ST_ARCH;
    else if (!comp_ok)                                           status = ST_COMP;
    else if (view.size_bad)                                      status = ST_SIZE;
    else if (crc_en && (~view.data_crc_run != view.data_crc_stored))
      status = ST_DATA_CRC;
    else                                                         status = ST_OK;
  end

  always_comb begin
    result.status       = status;
    result.image_type   = (status == ST_OK) ? type_b : 8'd0;
    result.is_kernel    = (status == ST_OK) &&
                          ((type_b == TYPE_KERNEL) || (type_b == TYPE_KERNEL_NOLOAD));
    result.is_ramdisk   = (status == ST_OK) && (type_b == TYPE_RAMDISK);
    result.load_address = (status == ST_SHORT) ? 32'd0 : view.load_word;
    result.entry_point  = (status == ST_SHORT) ? 32'd0 : view.entry_word;
  end

endmodule
`default_nettype wire
